[hdl/utc_pkg.sv]
// ----------------------------------------------------------------------------
// utc_pkg: shared types and constants
// Payload structs, boundary codes and register map of the upwind
// tridiagonal coefficient block.
// ----------------------------------------------------------------------------
package utc_pkg;

  // fixed-point format of all data values
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 31;
  localparam int unsigned PADDR_W   = 3;
  localparam int unsigned PDATA_W   = 32;

  localparam logic [CFG_W-1:0] INV_TWO_STEP_SQ_RST = CFG_W'(32768);
  localparam logic [CFG_W-1:0] INV_STEP_RST        = CFG_W'(65536);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_INV_TWO_STEP_SQ = 1'b0,
    REG_INV_STEP        = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    POS_OPEN         = 2'd0,
    POS_CLOSED_LEFT  = 2'd1,
    POS_CLOSED_RIGHT = 2'd2,
    POS_LAND         = 2'd3
  } pos_code_e;

  typedef struct packed {
    pos_code_e          pos_code;
    logic signed [31:0] sigma_left;
    logic signed [31:0] sigma_center;
    logic signed [31:0] sigma_right;
    logic signed [31:0] vel_left;
    logic signed [31:0] vel_center;
    logic signed [31:0] vel_right;
  } cmd_t;

  typedef struct packed {
    logic signed [31:0] coef_lower;
    logic signed [31:0] coef_diag;
    logic signed [31:0] coef_upper;
  } res_t;

endpackage

[hdl/upwind_tridiagonal_coefficients.sv]
// ----------------------------------------------------------------------------
// upwind_tridiagonal_coefficients
// Lower, diagonal and upper coefficients of one implicit upwind
// advection-diffusion row per grid cell, signed fixed point, saturated.
// ----------------------------------------------------------------------------
// Usage:
//   A cell is taken on the rising edge where start is high and busy is low.
//   busy never rises, so one cell can be issued in every clock cycle.
//   Each result shows on res_o for exactly one cycle with res_valid_o high,
//   once its cell has passed the pipeline; results keep issue order.
//   The receiver cannot stall, so nothing is held back or dropped.
//   The pipeline stages are the input register, sums and magnitudes,
//   split partial products, product combine and rounding, then term sum and
//   saturation into the result register. Throughput is one cell per cycle.
//   The two reciprocal registers (inv_two_step_sq at 0x0, inv_step at 0x4)
//   are written over the APB port; pready is always high. Write them only
//   while no cell is in flight.
//   Reset clears the pipeline valid bits and loads the register defaults;
//   no result is issued until a new cell is started.
// ----------------------------------------------------------------------------
module upwind_tridiagonal_coefficients
  import utc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  cmd_t               cmd_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned MAG_W  = DATA_W + 2;           // |sl + 2sc + sr|
  localparam int unsigned HALF_W = (MAG_W + 1) / 2;
  localparam int unsigned PP_W   = HALF_W + CFG_W;       // partial product
  localparam int unsigned PV_W   = DATA_W + CFG_W;       // velocity product
  localparam int unsigned PROD_W = 64;
  localparam int unsigned RW     = PROD_W - FRAC_BITS;   // rounded magnitude
  localparam int unsigned TW     = RW + 1;               // signed term
  localparam int unsigned SW     = TW + 1;               // sum of two terms
  localparam logic [PROD_W-1:0] RND = PROD_W'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    pos_code_e           pos;
    logic [MAG_W-1:0]    mag_lc;
    logic [MAG_W-1:0]    mag_cr;
    logic [MAG_W-1:0]    mag_s3;
    logic                neg_lc;
    logic                neg_cr;
    logic                neg_s3;
    logic [DATA_W-1:0]   mag_vl;
    logic [DATA_W-1:0]   mag_vc;
    logic [DATA_W-1:0]   mag_vr;
    logic                vl_pos;
    logic                vc_pos;
    logic                vr_nonpos;
  } s2_t;

  typedef struct packed {
    pos_code_e           pos;
    logic [PP_W-1:0]     pl_lc;
    logic [PP_W-1:0]     ph_lc;
    logic [PP_W-1:0]     pl_cr;
    logic [PP_W-1:0]     ph_cr;
    logic [PP_W-1:0]     pl_s3;
    logic [PP_W-1:0]     ph_s3;
    logic                neg_lc;
    logic                neg_cr;
    logic                neg_s3;
    logic [PV_W-1:0]     pv_vl;
    logic [PV_W-1:0]     pv_vc;
    logic [PV_W-1:0]     pv_vr;
    logic                vl_pos;
    logic                vc_pos;
    logic                vr_nonpos;
  } s3_t;

  typedef struct packed {
    pos_code_e           pos;
    logic [RW-1:0]       r_lc;
    logic [RW-1:0]       r_cr;
    logic [RW-1:0]       r_s3;
    logic                neg_lc;
    logic                neg_cr;
    logic                neg_s3;
    logic [RW-1:0]       r_vl;
    logic [RW-1:0]       r_vc;
    logic [RW-1:0]       r_vr;
    logic                vl_pos;
    logic                vc_pos;
    logic                vr_nonpos;
  } s4_t;

  // configuration registers
  logic [CFG_W-1:0] inv_two_step_sq_q;
  logic [CFG_W-1:0] inv_step_q;
  logic             cfg_we;
  reg_idx_e         cfg_idx;

  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, res_v_q;
  cmd_t s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  res_t res_d, res_q;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_two_step_sq_q <= INV_TWO_STEP_SQ_RST;
      inv_step_q        <= INV_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_INV_TWO_STEP_SQ: inv_two_step_sq_q <= pwdata[CFG_W-1:0];
        REG_INV_STEP:        inv_step_q        <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_INV_TWO_STEP_SQ: prdata = PDATA_W'(inv_two_step_sq_q);
      REG_INV_STEP:        prdata = PDATA_W'(inv_step_q);
      default:             prdata = '0;
    endcase
  end

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [MAG_W-1:0] x);
    mag_of = x[MAG_W-1] ? MAG_W'(-x) : MAG_W'(x);
  endfunction

  function automatic logic [DATA_W-1:0] vmag_of(input logic signed [DATA_W-1:0] x);
    vmag_of = x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
  endfunction

  function automatic logic [RW-1:0] round_of(input logic [PROD_W-1:0] p);
    logic [PROD_W-1:0] t;
    t = p + RND;
    round_of = t[PROD_W-1:FRAC_BITS];
  endfunction

  // negative flag set means the term is subtracted
  function automatic logic signed [TW-1:0] term_of(input logic [RW-1:0] r,
                                                   input logic neg);
    logic signed [TW-1:0] t;
    t = $signed({1'b0, r});
    term_of = neg ? -t : t;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat_of(input logic signed [SW-1:0] x);
    logic [SW-DATA_W:0] hi;
    hi = x[SW-1:DATA_W-1];
    if ((&hi) || !(|hi)) begin
      sat_of = x[DATA_W-1:0];
    end else if (x[SW-1]) begin
      sat_of = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat_of = {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

  // stage 2: neighbor sums and magnitudes
  always_comb begin
    logic signed [MAG_W-1:0] sl, sc, sr, s_lc, s_cr, s_s3;
    sl   = MAG_W'(s1_q.sigma_left);
    sc   = MAG_W'(s1_q.sigma_center);
    sr   = MAG_W'(s1_q.sigma_right);
    s_lc = sl + sc;
    s_cr = sc + sr;
    s_s3 = sl + (sc <<< 1) + sr;
    s2_d.pos       = s1_q.pos_code;
    s2_d.mag_lc    = mag_of(s_lc);
    s2_d.mag_cr    = mag_of(s_cr);
    s2_d.mag_s3    = mag_of(s_s3);
    s2_d.neg_lc    = s_lc[MAG_W-1];
    s2_d.neg_cr    = s_cr[MAG_W-1];
    s2_d.neg_s3    = s_s3[MAG_W-1];
    s2_d.mag_vl    = vmag_of(s1_q.vel_left);
    s2_d.mag_vc    = vmag_of(s1_q.vel_center);
    s2_d.mag_vr    = vmag_of(s1_q.vel_right);
    s2_d.vl_pos    = !s1_q.vel_left[DATA_W-1] && (|s1_q.vel_left);
    s2_d.vc_pos    = !s1_q.vel_center[DATA_W-1] && (|s1_q.vel_center);
    s2_d.vr_nonpos = s1_q.vel_right[DATA_W-1] || !(|s1_q.vel_right);
  end

  // stage 3: diffusion magnitudes split in halves to keep multipliers narrow
  always_comb begin
    s3_d.pos       = s2_q.pos;
    s3_d.pl_lc     = PP_W'(s2_q.mag_lc[HALF_W-1:0]) * PP_W'(inv_two_step_sq_q);
    s3_d.ph_lc     = PP_W'(s2_q.mag_lc[MAG_W-1:HALF_W]) * PP_W'(inv_two_step_sq_q);
    s3_d.pl_cr     = PP_W'(s2_q.mag_cr[HALF_W-1:0]) * PP_W'(inv_two_step_sq_q);
    s3_d.ph_cr     = PP_W'(s2_q.mag_cr[MAG_W-1:HALF_W]) * PP_W'(inv_two_step_sq_q);
    s3_d.pl_s3     = PP_W'(s2_q.mag_s3[HALF_W-1:0]) * PP_W'(inv_two_step_sq_q);
    s3_d.ph_s3     = PP_W'(s2_q.mag_s3[MAG_W-1:HALF_W]) * PP_W'(inv_two_step_sq_q);
    s3_d.neg_lc    = s2_q.neg_lc;
    s3_d.neg_cr    = s2_q.neg_cr;
    s3_d.neg_s3    = s2_q.neg_s3;
    s3_d.pv_vl     = PV_W'(s2_q.mag_vl) * PV_W'(inv_step_q);
    s3_d.pv_vc     = PV_W'(s2_q.mag_vc) * PV_W'(inv_step_q);
    s3_d.pv_vr     = PV_W'(s2_q.mag_vr) * PV_W'(inv_step_q);
    s3_d.vl_pos    = s2_q.vl_pos;
    s3_d.vc_pos    = s2_q.vc_pos;
    s3_d.vr_nonpos = s2_q.vr_nonpos;
  end

  // stage 4: combine halves, round half away from zero on the magnitude
  always_comb begin
    logic [PROD_W-1:0] p_lc, p_cr, p_s3;
    p_lc = PROD_W'({s3_q.ph_lc, {HALF_W{1'b0}}}) + PROD_W'(s3_q.pl_lc);
    p_cr = PROD_W'({s3_q.ph_cr, {HALF_W{1'b0}}}) + PROD_W'(s3_q.pl_cr);
    p_s3 = PROD_W'({s3_q.ph_s3, {HALF_W{1'b0}}}) + PROD_W'(s3_q.pl_s3);
    s4_d.pos       = s3_q.pos;
    s4_d.r_lc      = round_of(p_lc);
    s4_d.r_cr      = round_of(p_cr);
    s4_d.r_s3      = round_of(p_s3);
    s4_d.neg_lc    = s3_q.neg_lc;
    s4_d.neg_cr    = s3_q.neg_cr;
    s4_d.neg_s3    = s3_q.neg_s3;
    s4_d.r_vl      = round_of(PROD_W'(s3_q.pv_vl));
    s4_d.r_vc      = round_of(PROD_W'(s3_q.pv_vc));
    s4_d.r_vr      = round_of(PROD_W'(s3_q.pv_vr));
    s4_d.vl_pos    = s3_q.vl_pos;
    s4_d.vc_pos    = s3_q.vc_pos;
    s4_d.vr_nonpos = s3_q.vr_nonpos;
  end

  // stage 5: pick terms by boundary code, add and saturate
  always_comb begin
    logic signed [TW-1:0] lo_d, lo_a, dg_d, dg_a, up_d, up_a;
    logic                 use_lo, use_up;
    use_lo = (s4_q.pos == POS_OPEN) || (s4_q.pos == POS_CLOSED_RIGHT);
    use_up = (s4_q.pos == POS_OPEN) || (s4_q.pos == POS_CLOSED_LEFT);
    // off-diagonals carry the negated diffusion term
    lo_d = use_lo ? term_of(s4_q.r_lc, !s4_q.neg_lc) : '0;
    lo_a = (use_lo && s4_q.vl_pos) ? term_of(s4_q.r_vl, 1'b1) : '0;
    up_d = use_up ? term_of(s4_q.r_cr, !s4_q.neg_cr) : '0;
    up_a = (use_up && s4_q.vr_nonpos) ? term_of(s4_q.r_vr, 1'b1) : '0;
    unique case (s4_q.pos)
      POS_OPEN: begin
        dg_d = term_of(s4_q.r_s3, s4_q.neg_s3);
        dg_a = term_of(s4_q.r_vc, 1'b0);
      end
      POS_CLOSED_LEFT: begin
        dg_d = term_of(s4_q.r_cr, s4_q.neg_cr);
        dg_a = s4_q.vc_pos ? term_of(s4_q.r_vc, 1'b0) : '0;
      end
      POS_CLOSED_RIGHT: begin
        dg_d = term_of(s4_q.r_lc, s4_q.neg_lc);
        dg_a = s4_q.vc_pos ? '0 : term_of(s4_q.r_vc, 1'b0);
      end
      default: begin
        dg_d = '0;
        dg_a = '0;
      end
    endcase
    res_d.coef_lower = sat_of(SW'(lo_d) + SW'(lo_a));
    res_d.coef_diag  = sat_of(SW'(dg_d) + SW'(dg_a));
    res_d.coef_upper = sat_of(SW'(up_d) + SW'(up_a));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      res_v_q <= 1'b0;
    end else begin
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      res_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= cmd_i;
    end
    s2_q  <= s2_d;
    s3_q  <= s3_d;
    s4_q  <= s4_d;
    res_q <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

  // every start transaction yields a result after the full pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##5 res_valid_o)
    else $error("result strobe missing after start transaction");

  // a result is only issued for a cell that went through stage four
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(s4_v_q))
    else $error("result strobe without a cell in flight");

  // land cells give an all-zero row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && ($past(s4_q.pos) == POS_LAND)) |->
      (res_o.coef_lower == '0 && res_o.coef_diag == '0 && res_o.coef_upper == '0))
    else $error("land cell with nonzero coefficients");

  // a closed side drops its off-diagonal coefficient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |->
      (($past(s4_q.pos) != POS_CLOSED_LEFT || res_o.coef_lower == '0) &&
       ($past(s4_q.pos) != POS_CLOSED_RIGHT || res_o.coef_upper == '0)))
    else $error("closed boundary with nonzero off-diagonal");

endmodule
